[hdl/smef_pkg.sv]
// Shared constants and types of the spike/median/EMA filter.
package smef_pkg;

   // Configuration register layout
   localparam int THRESH_BITS   = 12;
   localparam int ALPHA_BITS    = 9;
   localparam int CSR_DATA_BITS = 12;
   localparam int CSR_IDX_BITS  = 1;

   localparam logic [CSR_IDX_BITS-1:0] CSR_SPIKE_THRESHOLD = 1'b0;
   localparam logic [CSR_IDX_BITS-1:0] CSR_EMA_ALPHA       = 1'b1;

   localparam logic [THRESH_BITS-1:0] THRESH_RESET = 12'd20;
   localparam logic [ALPHA_BITS-1:0]  ALPHA_RESET  = 9'd51;
   localparam logic [ALPHA_BITS-1:0]  ALPHA_ONE    = 9'd256;

   // Fractional bits of the moving average
   localparam int FRAC_BITS = 8;

   // Compare flags a window cell reports against the current candidate
   typedef struct packed {
      logic below;
      logic same;
   } smef_cell_flags_type;

   // Controls of the averaging unit
   typedef struct packed {
      logic mul_en;
      logic add_en;
      logic seed;
   } smef_ema_ctrl_type;

endpackage

[hdl/smef_req_if.sv]
// Request channel: one raw ADC sample per item.
interface smef_req_if #(
   parameter int SAMPLE_BITS = 12
);
   logic                   valid;
   logic                   ready;
   logic [SAMPLE_BITS-1:0] sample;

   modport source (output valid, output sample, input ready);
   modport sink   (input valid, input sample, output ready);
endinterface

[hdl/smef_rsp_if.sv]
// Response channel: filtered value, spike flag and window median.
interface smef_rsp_if #(
   parameter int SAMPLE_BITS = 12
);
   logic                   valid;
   logic                   ready;
   logic [SAMPLE_BITS-1:0] filtered;
   logic                   spike_seen;
   logic [SAMPLE_BITS-1:0] median_value;

   modport source (output valid, output filtered, output spike_seen,
                   output median_value, input ready);
   modport sink   (input valid, input filtered, input spike_seen,
                   input median_value, output ready);
endinterface

[hdl/smef_cell.sv]
// One window cell: holds a sample, shifts to its neighbor, compares to the candidate.
module smef_cell #(
   parameter int SAMPLE_BITS = 12
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          shift_en,
   input  logic [SAMPLE_BITS-1:0]        data_in,
   input  logic                          valid_in,
   input  logic [SAMPLE_BITS-1:0]        cand,
   output logic [SAMPLE_BITS-1:0]        data_out,
   output logic                          valid_out,
   output smef_pkg::smef_cell_flags_type flags_out
);

   logic [SAMPLE_BITS-1:0]        data_ff;
   logic                          valid_ff;
   smef_pkg::smef_cell_flags_type flags_ff;
   smef_pkg::smef_cell_flags_type flags_in;

   // sample and occupancy move one cell down the chain when shifting
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (shift_en) begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (shift_en) begin
         data_ff <= data_in;
      end
   end

   // compare against the candidate seen this cycle
   always_comb begin
      flags_in.below = valid_ff && (data_ff < cand);
      flags_in.same  = valid_ff && (data_ff == cand);
   end

   always_ff @(posedge clock) begin
      flags_ff <= flags_in;
   end

   assign data_out  = data_ff;
   assign valid_out = valid_ff;
   assign flags_out = flags_ff;

endmodule

[hdl/smef_ema.sv]
// Moving average unit: 12.8 fixed point, multiply then accumulate.
module smef_ema #(
   parameter int SAMPLE_BITS = 12
) (
   input  logic                                clock,
   input  logic                                reset,
   input  smef_pkg::smef_ema_ctrl_type         ctrl,
   input  logic [SAMPLE_BITS-1:0]              med,
   input  logic [smef_pkg::ALPHA_BITS-1:0]     alpha,
   output logic [SAMPLE_BITS-1:0]              avg_int
);

   localparam int AW = SAMPLE_BITS + smef_pkg::FRAC_BITS;
   localparam int DW = AW + 1;
   localparam int PW = DW + smef_pkg::ALPHA_BITS + 1;

   logic [AW-1:0]        avg_ff;
   logic [AW-1:0]        avg_in;
   logic signed [DW-1:0] diff;
   logic signed [PW-1:0] prod;
   logic signed [PW-1:0] prod_ff;
   logic signed [PW-1:0] step_full;
   logic signed [DW-1:0] step_s;
   logic signed [DW-1:0] avg_sum;

   // x*256 - y, then alpha times that
   assign diff = $signed({1'b0, med, {smef_pkg::FRAC_BITS{1'b0}}})
               - $signed({1'b0, avg_ff});
   assign prod = diff * $signed({1'b0, alpha});

   always_ff @(posedge clock) begin
      if (ctrl.mul_en) begin
         prod_ff <= prod;
      end
   end

   // arithmetic shift floors toward minus infinity
   assign step_full = prod_ff >>> smef_pkg::FRAC_BITS;
   assign step_s    = step_full[DW-1:0];
   assign avg_sum   = $signed({1'b0, avg_ff}) + step_s;

   always_comb begin
      avg_in = avg_ff;
      if (ctrl.seed) begin
         avg_in = {med, {smef_pkg::FRAC_BITS{1'b0}}};
      end else if (ctrl.add_en) begin
         avg_in = avg_sum[AW-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         avg_ff <= '0;
      end else begin
         avg_ff <= avg_in;
      end
   end

   assign avg_int = avg_ff[AW-1:smef_pkg::FRAC_BITS];

endmodule

[hdl/spike_median_ema_filter.sv]
// Top level: spike rejection, rotating-window median and moving average.
//
// Each request carries one ADC sample. The sample is spike-checked against
// the last good value and shifted into a chain of WINDOW cells. The median
// is then found by rotating the chain once around: each cycle the sample at
// the tail is the candidate, every cell compares against it, and the counts
// are checked against the median rank in the following cycle. A request
// passes from acceptance through the rotation of the chain, a state to
// check the last candidate, one each for the average's multiply and add,
// and one to load the response register. A new request is accepted once
// the previous one has reached the response register, even while that
// response still waits to be taken. Registers may be written at any time
// the block is idle; no clearing pass is needed after reset.
module spike_median_ema_filter #(
   parameter int WINDOW      = 15,
   parameter int SAMPLE_BITS = 12
) (
   input  logic                                  clock,
   input  logic                                  reset,
   smef_req_if.sink                              req_bus,
   smef_rsp_if.source                            rsp_bus,
   input  logic                                  csr_we,
   input  logic [smef_pkg::CSR_IDX_BITS-1:0]     csr_index,
   input  logic [smef_pkg::CSR_DATA_BITS-1:0]    csr_wdata
);

   localparam int CW    = $clog2(WINDOW + 1);
   localparam int SW    = $clog2(WINDOW);
   localparam int CMP_W = (SAMPLE_BITS > smef_pkg::THRESH_BITS) ?
                          SAMPLE_BITS : smef_pkg::THRESH_BITS;

   typedef enum logic [5:0] {
      S_IDLE = 6'b000001,
      S_RANK = 6'b000010,
      S_TAIL = 6'b000100,
      S_MUL  = 6'b001000,
      S_ADD  = 6'b010000,
      S_LOAD = 6'b100000
   } state_type;

   state_type state_ff, state_in;

   logic [smef_pkg::THRESH_BITS-1:0] thresh_ff;
   logic [smef_pkg::ALPHA_BITS-1:0]  alpha_ff;
   logic [smef_pkg::ALPHA_BITS-1:0]  alpha_sat;

   logic [SAMPLE_BITS-1:0] last_good_ff;
   logic                   primed_ff;
   logic [CW-1:0]          fill_count_ff;
   logic [SW-1:0]          step_ff;
   logic                   first_ff;
   logic                   spike_ff;

   logic                   accept;
   logic [SAMPLE_BITS-1:0] ref_val;
   logic [SAMPLE_BITS-1:0] delta;
   logic                   spike;
   logic [SAMPLE_BITS-1:0] used;

   logic [SAMPLE_BITS-1:0]        cell_data  [WINDOW];
   logic [WINDOW-1:0]             cell_valid;
   smef_pkg::smef_cell_flags_type cell_flags [WINDOW];
   logic [WINDOW-1:0]             below_vec;
   logic [WINDOW-1:0]             same_vec;
   logic                          shift_en;
   logic [SAMPLE_BITS-1:0]        head_data;
   logic                          head_valid;

   logic [SAMPLE_BITS-1:0] cand_ff;
   logic                   cand_vld_ff;
   logic                   chk_ff;
   logic [CW-1:0]          rank;
   logic [CW-1:0]          below_cnt;
   logic [CW-1:0]          same_cnt;
   logic [CW:0]            upper_cnt;
   logic                   hit;
   logic [SAMPLE_BITS-1:0] med_ff;

   smef_pkg::smef_ema_ctrl_type ema_ctrl;
   logic [SAMPLE_BITS-1:0]      avg_int;

   logic                   rsp_valid_ff;
   logic [SAMPLE_BITS-1:0] rsp_filtered_ff;
   logic                   rsp_spike_ff;
   logic [SAMPLE_BITS-1:0] rsp_median_ff;
   logic                   rsp_load;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         thresh_ff <= smef_pkg::THRESH_RESET;
         alpha_ff  <= smef_pkg::ALPHA_RESET;
      end else if (csr_we) begin
         case (csr_index)
            smef_pkg::CSR_SPIKE_THRESHOLD: thresh_ff <= csr_wdata[smef_pkg::THRESH_BITS-1:0];
            smef_pkg::CSR_EMA_ALPHA:       alpha_ff  <= csr_wdata[smef_pkg::ALPHA_BITS-1:0];
            default: ;
         endcase
      end
   end

   assign alpha_sat = (alpha_ff > smef_pkg::ALPHA_ONE) ? smef_pkg::ALPHA_ONE : alpha_ff;

   // request handshake
   assign req_bus.ready = (state_ff == S_IDLE);
   assign accept        = req_bus.valid && req_bus.ready;

   // spike check; the first sample is its own reference
   assign ref_val = primed_ff ? last_good_ff : req_bus.sample;
   assign delta   = (req_bus.sample > ref_val) ? (req_bus.sample - ref_val)
                                               : (ref_val - req_bus.sample);
   assign spike   = CMP_W'(delta) > CMP_W'(thresh_ff);
   assign used    = spike ? last_good_ff : req_bus.sample;

   always_ff @(posedge clock) begin
      if (reset) begin
         last_good_ff  <= '0;
         primed_ff     <= 1'b0;
         fill_count_ff <= '0;
      end else if (accept) begin
         last_good_ff <= used;
         primed_ff    <= 1'b1;
         if (fill_count_ff < CW'(WINDOW)) begin
            fill_count_ff <= fill_count_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         first_ff <= !primed_ff;
         spike_ff <= spike;
      end
   end

   // cell chain: load on accept, rotate during the rank search
   assign shift_en   = accept || (state_ff == S_RANK);
   assign head_data  = accept ? used : cell_data[WINDOW-1];
   assign head_valid = accept ? 1'b1 : cell_valid[WINDOW-1];

   for (genvar k = 0; k < WINDOW; k++) begin : g_cell
      logic [SAMPLE_BITS-1:0] din;
      logic                   vin;
      if (k == 0) begin : g_head
         assign din = head_data;
         assign vin = head_valid;
      end else begin : g_body
         assign din = cell_data[k-1];
         assign vin = cell_valid[k-1];
      end

      smef_cell #(
         .SAMPLE_BITS (SAMPLE_BITS)
      ) u_cell (
         .clock     (clock),
         .reset     (reset),
         .shift_en  (shift_en),
         .data_in   (din),
         .valid_in  (vin),
         .cand      (cell_data[WINDOW-1]),
         .data_out  (cell_data[k]),
         .valid_out (cell_valid[k]),
         .flags_out (cell_flags[k])
      );

      assign below_vec[k] = cell_flags[k].below;
      assign same_vec[k]  = cell_flags[k].same;
   end

   // candidate registered alongside the cell flags
   always_ff @(posedge clock) begin
      cand_ff     <= cell_data[WINDOW-1];
      cand_vld_ff <= cell_valid[WINDOW-1];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         chk_ff <= 1'b0;
      end else begin
         chk_ff <= (state_ff == S_RANK);
      end
   end

   // rank test: below <= rank < below + same
   assign rank      = fill_count_ff >> 1;
   assign below_cnt = CW'($countones(below_vec));
   assign same_cnt  = CW'($countones(same_vec));
   assign upper_cnt = {1'b0, below_cnt} + {1'b0, same_cnt};
   assign hit       = chk_ff && cand_vld_ff && (below_cnt <= rank)
                      && ({1'b0, rank} < upper_cnt);

   always_ff @(posedge clock) begin
      if (hit) begin
         med_ff <= cand_ff;
      end
   end

   // sequencer
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: if (accept) state_in = S_RANK;
         S_RANK: if (step_ff == SW'(WINDOW - 1)) state_in = S_TAIL;
         S_TAIL: state_in = S_MUL;
         S_MUL:  state_in = S_ADD;
         S_ADD:  state_in = S_LOAD;
         S_LOAD: if (rsp_load) state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         step_ff  <= '0;
      end else begin
         state_ff <= state_in;
         if (state_ff == S_RANK) begin
            step_ff <= (step_ff == SW'(WINDOW - 1)) ? '0 : step_ff + 1'b1;
         end
      end
   end

   // averaging unit: first median seeds it, later ones multiply then add once
   always_comb begin
      ema_ctrl.mul_en = (state_ff == S_MUL);
      ema_ctrl.add_en = (state_ff == S_ADD) && !first_ff;
      ema_ctrl.seed   = (state_ff == S_MUL) && first_ff;
   end

   smef_ema #(
      .SAMPLE_BITS (SAMPLE_BITS)
   ) u_ema (
      .clock   (clock),
      .reset   (reset),
      .ctrl    (ema_ctrl),
      .med     (med_ff),
      .alpha   (alpha_sat),
      .avg_int (avg_int)
   );

   // response register; the load stage waits here for a free slot
   assign rsp_load = (state_ff == S_LOAD) && (!rsp_valid_ff || rsp_bus.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (rsp_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_bus.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_filtered_ff <= avg_int;
         rsp_spike_ff    <= spike_ff;
         rsp_median_ff   <= med_ff;
      end
   end

   assign rsp_bus.valid        = rsp_valid_ff;
   assign rsp_bus.filtered     = rsp_filtered_ff;
   assign rsp_bus.spike_seen   = rsp_spike_ff;
   assign rsp_bus.median_value = rsp_median_ff;

   // checks
   a_fill_matches_cells: assert property (@(posedge clock) disable iff (reset)
      fill_count_ff == CW'($countones(cell_valid)))
      else $error("fill count disagrees with occupied cells");

   a_accept_starts_rank: assert property (@(posedge clock) disable iff (reset)
      accept |=> (state_ff == S_RANK) && (step_ff == '0))
      else $error("rank search did not start after request");

   a_spike_keeps_last_good: assert property (@(posedge clock) disable iff (reset)
      accept && spike |=> last_good_ff == $past(last_good_ff))
      else $error("spike changed last good sample");

   a_rsp_after_add: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == S_LOAD))
      else $error("response raised outside the load stage");

endmodule
